// ===== hdl/psd_pkg.sv =====
package psd_pkg;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = SPEED_W + 1;   // target - measured
  localparam int DIFF_W  = SPEED_W + 2;   // err - previous err
  localparam int DUTY_W  = 7;
  localparam int FLAG_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Integral accumulator width
  localparam int INTEGRAL_BITS = 32;

  // Product and sum widths
  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_D_W = GAIN_W + DIFF_W;
  localparam int PROD_I_W = GAIN_W + INTEGRAL_BITS;
  localparam int SUM_W    = PROD_I_W + 2;

  // Drive limits and duty mapping
  localparam int DRIVE_LOW  = 1;
  localparam int DRIVE_HIGH = 254;
  localparam int MAP_IN_START = 1;
  localparam int MAP_IN_END   = 255;
  localparam int DUTY_START = 65;
  localparam int DUTY_END   = 98;
  localparam int DUTY_SPAN  = DUTY_END - DUTY_START;
  localparam int MAP_DIV    = MAP_IN_END - MAP_IN_START;
  localparam int DRIVE_OFS_W = 8;
  localparam int MAP_X_W     = 14;   // DUTY_SPAN * 253 < 2**14
  // x / 254 == (x * MAP_RECIP) >> MAP_SHIFT, exact for x < 2**14
  localparam int MAP_SHIFT  = 21;
  localparam int MAP_RECIP  = ((1 << MAP_SHIFT) + MAP_DIV - 1) / MAP_DIV;
  localparam int MAP_PROD_W = 27;
  localparam int MAP_Q_W    = 6;

  // Threshold divide by ten: t / 10 == (t * DIV10_RECIP) >> DIV10_SHIFT for 16-bit t
  localparam int THRESH_DIV   = 10;
  localparam int DIV10_SHIFT  = 19;
  localparam int DIV10_RECIP  = ((1 << DIV10_SHIFT) + THRESH_DIV - 1) / THRESH_DIV;
  localparam int DIV10_PROD_W = SPEED_W + 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

  // Clamp status codes
  typedef enum logic [FLAG_W-1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_t;

endpackage

// ===== hdl/psd_integ.sv =====
module psd_integ
  import psd_pkg::*;
(
  input  logic [SPEED_W-1:0]              target_speed,
  input  logic signed [ERR_W-1:0]         err,
  input  logic signed [INTEGRAL_BITS-1:0] integ,
  output logic signed [INTEGRAL_BITS-1:0] integ_next
);

  localparam int SUM_IW = INTEGRAL_BITS + 1;
  localparam logic signed [SUM_IW-1:0] INTEG_MAX =
    SUM_IW'((65'sd1 <<< (INTEGRAL_BITS - 1)) - 65'sd1);
  localparam logic signed [SUM_IW-1:0] INTEG_MIN = -INTEG_MAX - SUM_IW'(1);

  logic [DIV10_PROD_W-1:0]  div_prod;
  logic [SPEED_W-1:0]       thresh;
  logic signed [SUM_IW-1:0] acc;
  logic                     below;

  always_comb begin
    // target / 10 by reciprocal multiply
    div_prod = DIV10_PROD_W'(target_speed) * DIV10_PROD_W'(DIV10_RECIP);
    thresh   = SPEED_W'(div_prod[DIV10_PROD_W-1:DIV10_SHIFT]);
    below    = err < $signed({1'b0, thresh});
    acc      = SUM_IW'(integ) + SUM_IW'(err);
    if (!below) begin
      integ_next = '0;
    end else if (acc > INTEG_MAX) begin
      integ_next = INTEG_MAX[INTEGRAL_BITS-1:0];
    end else if (acc < INTEG_MIN) begin
      integ_next = INTEG_MIN[INTEGRAL_BITS-1:0];
    end else begin
      integ_next = acc[INTEGRAL_BITS-1:0];
    end
  end

endmodule

// ===== hdl/psd_duty_map.sv =====
module psd_duty_map
  import psd_pkg::*;
(
  input  logic [DRIVE_OFS_W-1:0] drive_ofs,
  output logic [DUTY_W-1:0]      duty
);

  logic [MAP_X_W-1:0]    x;
  logic [MAP_PROD_W-1:0] prod;

  always_comb begin
    x    = MAP_X_W'(drive_ofs) * MAP_X_W'(DUTY_SPAN);
    prod = MAP_PROD_W'(x) * MAP_PROD_W'(MAP_RECIP);
    duty = DUTY_W'(DUTY_START) + DUTY_W'(prod[MAP_SHIFT +: MAP_Q_W]);
  end

endmodule

// ===== hdl/pid_speed_to_pwm_duty.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   32     tdata: target_speed [15:0], measured_speed [31:16]
// m_axis    out  8/2    tdata: duty_percent [6:0]; tuser: drive_clamped [1:0]
// cfg       in   2+16   index 0 prop_gain, 1 integ_gain, 2 deriv_gain
//
// One beat per cycle sustained while m_axis_tready stays high.
// Six register stages: input, error/integral, products, sum, clamp, output.
// The error/integral stage closes the state loop as each beat enters it.
// rst (synchronous) clears gains, previous error, integral and all valids.
// Each stage advances when empty or when the stage after it advances, so
// bubbles fill up while a result waits on m_axis_tready.
module pid_speed_to_pwm_duty
  import psd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // target_speed, measured_speed
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // duty_percent, zero pad
  output logic [FLAG_W-1:0]    m_axis_tuser    // drive_clamped
);

  // gains
  logic signed [GAIN_W-1:0] prop_gain;
  logic signed [GAIN_W-1:0] integ_gain;
  logic signed [GAIN_W-1:0] deriv_gain;

  // loop state
  logic signed [DIFF_W-1:0]        previous_error;
  logic signed [INTEGRAL_BITS-1:0] error_integral;
  logic signed [INTEGRAL_BITS-1:0] error_integral_next;

  // stage valids and advance
  logic v0, v1, v2, v3, v4, v5;
  logic adv0, adv1, adv2, adv3, adv4, adv5;

  // stage 0: input beat
  logic [SPEED_W-1:0] target0, measured0;
  // stage 1: error, difference, integral
  logic signed [ERR_W-1:0]         err;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [ERR_W-1:0]         err1;
  logic signed [DIFF_W-1:0]        diff1;
  logic signed [INTEGRAL_BITS-1:0] integ1;
  // stage 2: products
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [PROD_I_W-1:0] prod_i;
  // stage 3: drive sum
  logic signed [SUM_W-1:0] drive;
  // stage 4: clamped drive less one, flag
  logic [DRIVE_OFS_W-1:0] drive_ofs, drive_ofs_next;
  clamp_t                 flag4, flag4_next;
  // stage 5: output
  logic [DUTY_W-1:0] duty_next, duty5;
  clamp_t            flag5;

  // stall chain
  assign adv5 = !v5 || m_axis_tready;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign adv0 = !v0 || adv1;
  assign s_axis_tready = adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv0) v0 <= s_axis_tvalid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // config writes; unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0
  always_ff @(posedge clk) begin
    if (adv0 && s_axis_tvalid) begin
      target0   <= s_axis_tdata[SPEED_W-1:0];
      measured0 <= s_axis_tdata[2*SPEED_W-1:SPEED_W];
    end
  end

  // stage 1: error terms and integral update
  always_comb begin
    err  = $signed({1'b0, target0}) - $signed({1'b0, measured0});
    diff = DIFF_W'(err) - previous_error;
  end

  psd_integ u_integ (
    .target_speed (target0),
    .err          (err),
    .integ        (error_integral),
    .integ_next   (error_integral_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_integral <= '0;
    end else if (adv1 && v0) begin
      previous_error <= DIFF_W'(err);
      error_integral <= error_integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && v0) begin
      err1   <= err;
      diff1  <= diff;
      integ1 <= error_integral_next;
    end
  end

  // stage 2: one multiplier per term
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      prod_p <= PROD_P_W'(prop_gain) * PROD_P_W'(err1);
      prod_d <= PROD_D_W'(deriv_gain) * PROD_D_W'(diff1);
      prod_i <= PROD_I_W'(integ_gain) * PROD_I_W'(integ1);
    end
  end

  // stage 3: exact drive sum
  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      drive <= SUM_W'(prod_p) + SUM_W'(prod_d) + SUM_W'(prod_i);
    end
  end

  // stage 4: clamp to 1..254, keep drive - 1
  always_comb begin
    if (drive < SUM_W'(DRIVE_LOW)) begin
      drive_ofs_next = '0;
      flag4_next     = CLAMP_LOW;
    end else if (drive > SUM_W'(DRIVE_HIGH)) begin
      drive_ofs_next = DRIVE_OFS_W'(DRIVE_HIGH - MAP_IN_START);
      flag4_next     = CLAMP_HIGH;
    end else begin
      drive_ofs_next = drive[DRIVE_OFS_W-1:0] - DRIVE_OFS_W'(MAP_IN_START);
      flag4_next     = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      drive_ofs <= drive_ofs_next;
      flag4     <= flag4_next;
    end
  end

  // stage 5: linear map to duty
  psd_duty_map u_map (
    .drive_ofs (drive_ofs),
    .duty      (duty_next)
  );

  always_ff @(posedge clk) begin
    if (adv5 && v4) begin
      duty5 <= duty_next;
      flag5 <= flag4;
    end
  end

  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {1'b0, duty5};
  assign m_axis_tuser  = flag5;

endmodule

// ===== test/pid_speed_to_pwm_duty_tb.sv =====
`timescale 1ns / 100ps

module pid_speed_to_pwm_duty_tb;
  import psd_pkg::*;

  // No register name exists for index 3; the block must drop writes to it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Signed limits of the integral accumulator
  localparam longint INTEG_TOP = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
  localparam longint INTEG_BOT = -INTEG_TOP - 1;

  // Cycles with no beat on either side and no register write before giving up
  localparam int WATCHDOG_LIMIT = 2000;

  // One expected result beat
  typedef struct {
    logic [DUTY_W-1:0] duty;
    clamp_t            clamp;
  } pwm_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]  cfg_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;    // target_speed [15:0], measured_speed [31:16]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;         // duty_percent [6:0], zero pad [7]
  logic [FLAG_W-1:0]  m_axis_tuser;         // drive_clamped [1:0]

  // Controller state as the testbench sees it
  logic signed [GAIN_W-1:0]        kp_reg = '0;
  logic signed [GAIN_W-1:0]        ki_reg = '0;
  logic signed [GAIN_W-1:0]        kd_reg = '0;
  logic signed [ERR_W-1:0]         last_err = '0;
  logic signed [INTEGRAL_BITS-1:0] err_sum = '0;

  pwm_result_t duty_q[$];
  pwm_result_t due;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  // Gap switches for the two sides; cleared for the stretches with no idling
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;

  pid_speed_to_pwm_duty dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller prediction: one call per accepted input beat, pushes one result
  // ---------------------------------------------------------------------------
  function automatic void step_controller(input logic [SPEED_W-1:0] tgt,
                                          input logic [SPEED_W-1:0] meas);
    longint      e;
    longint      dlt;
    longint      acc;
    longint      drv;
    longint      duty_l;
    pwm_result_t res;
    e   = longint'(tgt) - longint'(meas);
    dlt = e - longint'(last_err);
    last_err = e[ERR_W-1:0];

    // Integral only runs while the error sits below a tenth of the target,
    // otherwise it is dumped; it saturates rather than wraps
    if (e < longint'(tgt) / THRESH_DIV) begin
      acc = longint'(err_sum) + e;
      if (acc > INTEG_TOP) acc = INTEG_TOP;
      else if (acc < INTEG_BOT) acc = INTEG_BOT;
      err_sum = acc[INTEGRAL_BITS-1:0];
    end else begin
      err_sum = '0;
    end

    drv = longint'(kp_reg) * e + longint'(kd_reg) * dlt +
          longint'(ki_reg) * longint'(err_sum);

    // Limits themselves are in range and carry no clamp flag
    res.clamp = CLAMP_NONE;
    if (drv < DRIVE_LOW) begin
      drv = DRIVE_LOW;
      res.clamp = CLAMP_LOW;
    end else if (drv > DRIVE_HIGH) begin
      drv = DRIVE_HIGH;
      res.clamp = CLAMP_HIGH;
    end

    // Multiply before divide; tops out at 97 for the highest drive
    duty_l   = DUTY_START + (longint'(DUTY_SPAN) * (drv - MAP_IN_START)) / MAP_DIV;
    res.duty = duty_l[DUTY_W-1:0];
    duty_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one speed sample; random gaps ahead of it when the sender idles
  task automatic push_speed_sample(input logic [SPEED_W-1:0] tgt,
                                   input logic [SPEED_W-1:0] meas);
    @(negedge clk);
    while (src_gaps && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {meas, tgt};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    step_controller(tgt, meas);
  endtask

  // Sender goes quiet until every outstanding result beat is back
  task automatic hold_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
  endtask

  // Empty pipeline plus a margin past the six-stage latency
  task automatic settle_pipeline();
    hold_for_results();
    repeat (8) @(posedge clk);
  endtask

  // Single-cycle register write; only called with the pipeline empty
  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx,
                            input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  kp_reg = val;
      REG_INTEG_GAIN: ki_reg = val;
      REG_DERIV_GAIN: kd_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] kp,
                           input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd);
    write_gain(REG_PROP_GAIN, kp);
    write_gain(REG_INTEG_GAIN, ki);
    write_gain(REG_DERIV_GAIN, kd);
  endtask

  function automatic logic [GAIN_W-1:0] small_gain();
    return GAIN_W'(int'($urandom_range(0, 10)) - 5);
  endfunction

  // Random sample, mostly close pairs so the integral keeps running and the
  // drive lands inside the clamp window; the rest full range and corners
  task automatic send_random_sample();
    int t;
    int m;
    t = int'($urandom_range(0, 65535));
    m = int'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      2, 3, 4, 5: m = t + int'($urandom_range(0, 80)) - 40;
      6: begin
        t = int'($urandom_range(0, 60));
        m = int'($urandom_range(0, 60));
      end
      7: begin
        t = 65535 - int'($urandom_range(0, 60));
        m = 65535 - int'($urandom_range(0, 60));
      end
      8: m = t;
      9: begin
        t = int'($urandom_range(0, 1)) * 65535;
        m = int'($urandom_range(0, 1)) * 65535;
      end
      default: ;
    endcase
    if (m < 0) m = 0;
    if (m > 65535) m = 65535;
    push_speed_sample(t[SPEED_W-1:0], m[SPEED_W-1:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Gains clear at reset: drive is zero, so every beat clamps low at duty 65
  task automatic test_reset_gains();
    push_speed_sample(16'd0, 16'd0);
    push_speed_sample(16'hFFFF, 16'd0);
    settle_pipeline();
  endtask

  // Pure proportional path with unit gain: drive equals the error, which
  // walks across both clamp edges and the duty ceiling
  task automatic test_drive_limits();
    set_gains(16'd1, 16'd0, 16'd0);
    push_speed_sample(16'd254, 16'd0);     // top of range, duty 97
    push_speed_sample(16'd255, 16'd0);     // just over, clamp high
    push_speed_sample(16'd1, 16'd0);       // bottom of range, no flag
    push_speed_sample(16'd0, 16'd0);       // just under, clamp low
    push_speed_sample(16'd2, 16'd0);
    push_speed_sample(16'd128, 16'd0);
    push_speed_sample(16'hFFFF, 16'd0);    // widest positive error
    push_speed_sample(16'd0, 16'hFFFF);    // widest negative error
    settle_pipeline();
    // Write to the unused index must leave all gains alone
    write_gain(REG_UNUSED, 16'h7FFF);
    push_speed_sample(16'd200, 16'd0);
    settle_pipeline();
  endtask

  // Derivative path alone: drive follows the change of error
  task automatic test_derivative_path();
    set_gains(16'd0, 16'd0, 16'd1);
    push_speed_sample(16'd0, 16'd0);
    push_speed_sample(16'd100, 16'd0);
    push_speed_sample(16'd100, 16'd0);
    push_speed_sample(16'd0, 16'd100);
    push_speed_sample(16'd200, 16'd0);
    settle_pipeline();
  endtask

  // Integral path alone: accumulate below target/10, dump at or above it
  task automatic test_integral_gate();
    set_gains(16'd0, 16'd1, 16'd0);
    push_speed_sample(16'd100, 16'd90);    // error equals threshold, dumped
    push_speed_sample(16'd100, 16'd91);    // one below, runs
    push_speed_sample(16'd100, 16'd91);
    push_speed_sample(16'd0, 16'd5);       // negative error still runs
    push_speed_sample(16'd9, 16'd0);       // threshold truncates to zero
    push_speed_sample(16'd0, 16'd0);       // zero error, zero threshold
    push_speed_sample(16'd10, 16'd0);
    settle_pipeline();
  endtask

  // Random samples under a spread of gain settings, extremes among them
  task automatic test_random_gains();
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: set_gains(small_gain(), small_gain(), small_gain());
        1: set_gains(small_gain(), 16'd0, small_gain());
        2: set_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
        3: set_gains(16'h7FFF, 16'h8000, 16'h7FFF);
        4: set_gains(16'h8000, 16'h7FFF, 16'h8000);
        5: set_gains(small_gain(), small_gain(), small_gain());
        default: set_gains(16'd0, small_gain(), small_gain());
      endcase
      // Phase 5 is the stretch with both sides running flat out
      src_gaps  = (k != 5);
      sink_gaps = (k != 5);
      for (int n = 0; n < 150; n++) begin
        if ((k == 1 && n == 75) || $urandom_range(0, 199) == 0)
          hold_for_results();
        send_random_sample();
      end
      settle_pipeline();
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_gains();
    test_drive_limits();
    test_derivative_path();
    test_integral_gate();
    test_random_gains();

    hold_for_results();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    m_axis_tready <= !(sink_gaps && $urandom_range(0, 99) < 27);
  end

  // Compare every result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (duty_q.size() == 0) begin
        $error("result beat with nothing expected: duty_percent %0d drive_clamped %0d",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        due = duty_q.pop_front();
        if (m_axis_tdata !== 8'(due.duty)) begin
          $error("duty_percent: expected %0d, got %0d", due.duty, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== due.clamp) begin
          $error("drive_clamped: expected %0d, got %0d", due.clamp, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any beat or register write counts as progress
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
